@@ design/ars_pkg.sv @@
// types, codes and constants shared by the send queue modules
package ars_pkg;

  localparam int TAG_W      = 8;
  localparam int SN_W       = 8;
  localparam int WAIT_W     = 8;
  localparam int CNT_W      = 4;
  localparam int MAX_REPORT = 8;

  localparam logic [WAIT_W-1:0] TIMEOUT_RESET = 8'd10;
  localparam logic [WAIT_W-1:0] WAIT_MAX      = 8'hFF;

  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_ACK  = 2'd1;
  localparam logic [1:0] CMD_SERV = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef enum logic [1:0] {
    OP_ENQ,
    OP_ACK,
    OP_SERV,
    OP_NONE
  } op_e;

  typedef enum logic [2:0] {
    PH_EMPTY = 3'd0,
    PH_READY = 3'd1,
    PH_SENT1 = 3'd2,
    PH_SENT2 = 3'd3,
    PH_SENT3 = 3'd4,
    PH_FAIL  = 3'd5,
    PH_SUCC  = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    KIND_QUEUED   = 3'd0,
    KIND_REJECT   = 3'd1,
    KIND_TRANSMIT = 3'd2,
    KIND_DONE_OK  = 3'd3,
    KIND_DONE_ERR = 3'd4,
    KIND_ACK_HIT  = 3'd5,
    KIND_ACK_MISS = 3'd6,
    KIND_NONE     = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ,
    ST_ACK,
    ST_SEND,
    ST_AGE,
    ST_PACK,
    ST_FINAL
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [TAG_W-1:0] tag;
    logic [SN_W-1:0]  sn;
  } cmd_t;

  typedef struct packed {
    kind_e            kind;
    logic [TAG_W-1:0] tag;
    logic [SN_W-1:0]  sn;
    logic [1:0]       attempt;
  } res_t;

  function automatic logic in_flight(phase_e p);
    return (p == PH_SENT1) || (p == PH_SENT2) || (p == PH_SENT3);
  endfunction

endpackage

@@ design/ars_front.sv @@
// front end: accepts input items, decodes the command and queues it for the back end
module ars_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                cmd_i,
  input  logic [ars_pkg::TAG_W-1:0] msg_tag_i,
  input  logic [ars_pkg::SN_W-1:0]  ack_sn_i,
  output logic                      cmd_valid_o,
  output ars_pkg::cmd_t             cmd_o,
  input  logic                      cmd_pop_i
);

  ars_pkg::cmd_t fifo_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  ars_pkg::cmd_t in_cmd;
  logic          push;
  logic          pop;

  always_comb begin
    in_cmd.tag = msg_tag_i;
    in_cmd.sn  = ack_sn_i;
    unique case (cmd_i)
      ars_pkg::CMD_ENQ:  in_cmd.op = ars_pkg::OP_ENQ;
      ars_pkg::CMD_ACK:  in_cmd.op = ars_pkg::OP_ACK;
      ars_pkg::CMD_SERV: in_cmd.op = ars_pkg::OP_SERV;
      default:           in_cmd.op = ars_pkg::OP_NONE;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

@@ design/ars_back.sv @@
// back end: slot store and sequencer that carries out enqueue, ack and service steps
module ars_back #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic [7:0]                cfg_data_i,
  input  logic                      cmd_valid_i,
  input  ars_pkg::cmd_t             cmd_i,
  output logic                      cmd_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output ars_pkg::res_t             res_o,
  output logic                      last_o
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [ars_pkg::CNT_W-1:0] MAX_REP_C = ars_pkg::CNT_W'(ars_pkg::MAX_REPORT);

  logic [ars_pkg::TAG_W-1:0]  tag_q   [QUEUE_DEPTH];
  ars_pkg::phase_e            phase_q [QUEUE_DEPTH];
  logic [ars_pkg::SN_W-1:0]   sn_q    [QUEUE_DEPTH];
  logic [ars_pkg::WAIT_W-1:0] wait_q  [QUEUE_DEPTH];

  ars_pkg::state_e            state_q, state_d;
  logic [CW-1:0]              j_q, j_d;
  logic [CW-1:0]              w_q, w_d;
  logic [CW-1:0]              fill_q, fill_d;
  logic [ars_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [ars_pkg::SN_W-1:0]   seq_q, seq_d;
  logic [ars_pkg::WAIT_W-1:0] tmo_q;
  ars_pkg::cmd_t              cmd_q, cmd_d;
  ars_pkg::res_t              pend_q, pend_d;
  logic                       pend_v_q, pend_v_d;
  ars_pkg::res_t              out_q, out_d;
  logic                       last_q, last_d;
  logic                       out_v_q, out_v_d;

  logic                       wr_en;
  logic [IW-1:0]              wr_idx;
  logic [ars_pkg::TAG_W-1:0]  wr_tag;
  ars_pkg::phase_e            wr_phase;
  logic [ars_pkg::SN_W-1:0]   wr_sn;
  logic [ars_pkg::WAIT_W-1:0] wr_wait;
  logic                       age_all;
  logic                       gen;
  ars_pkg::res_t              gen_res;

  logic [IW-1:0]              j_idx;
  logic [ars_pkg::TAG_W-1:0]  cur_tag;
  ars_pkg::phase_e            cur_phase;
  logic [ars_pkg::SN_W-1:0]   cur_sn;
  logic [ars_pkg::WAIT_W-1:0] cur_wait;
  ars_pkg::phase_e            ph_inc;
  logic                       at_end;
  logic                       cur_fly;
  logic                       cur_fin;
  logic                       can_push;
  logic                       full;
  logic                       ack_hit;
  logic                       send_new;
  logic                       send_re;
  logic                       rep_now;

  assign j_idx     = j_q[IW-1:0];
  assign cur_tag   = tag_q[j_idx];
  assign cur_phase = phase_q[j_idx];
  assign cur_sn    = sn_q[j_idx];
  assign cur_wait  = wait_q[j_idx];
  assign ph_inc    = ars_pkg::phase_e'(cur_phase + 3'd1);
  assign at_end    = (j_q == fill_q);
  assign cur_fly   = ars_pkg::in_flight(cur_phase);
  assign cur_fin   = (cur_phase == ars_pkg::PH_FAIL) || (cur_phase == ars_pkg::PH_SUCC);
  assign can_push  = !out_v_q || out_ready_i;
  assign full      = (fill_q == DEPTH_C);
  assign ack_hit   = cur_fly && (cur_sn == cmd_q.sn);
  assign send_new  = (cur_phase == ars_pkg::PH_READY);
  assign send_re   = cur_fly && (cur_wait >= tmo_q);
  assign rep_now   = cur_fin && (cnt_q < MAX_REP_C);

  assign cmd_pop_o   = (state_q == ars_pkg::ST_IDLE) && cmd_valid_i;
  assign out_valid_o = out_v_q;
  assign res_o       = out_q;
  assign last_o      = last_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ars_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            ars_pkg::OP_ENQ:  state_d = ars_pkg::ST_ENQ;
            ars_pkg::OP_ACK:  state_d = ars_pkg::ST_ACK;
            ars_pkg::OP_SERV: state_d = ars_pkg::ST_SEND;
            default:          state_d = ars_pkg::ST_FINAL;
          endcase
        end
      end
      ars_pkg::ST_ENQ: begin
        if (can_push) state_d = ars_pkg::ST_FINAL;
      end
      ars_pkg::ST_ACK: begin
        if (can_push && (at_end || ack_hit)) state_d = ars_pkg::ST_FINAL;
      end
      ars_pkg::ST_SEND: begin
        if (can_push) begin
          priority if (at_end || send_new) begin
            state_d = ars_pkg::ST_AGE;
          end else if (send_re && ph_inc != ars_pkg::PH_FAIL) begin
            state_d = ars_pkg::ST_AGE;
          end else begin
            state_d = ars_pkg::ST_SEND;
          end
        end
      end
      ars_pkg::ST_AGE: begin
        if (can_push) state_d = ars_pkg::ST_PACK;
      end
      ars_pkg::ST_PACK: begin
        if (can_push && at_end) state_d = ars_pkg::ST_FINAL;
      end
      ars_pkg::ST_FINAL: begin
        if (can_push) state_d = ars_pkg::ST_IDLE;
      end
      default: state_d = ars_pkg::ST_IDLE;
    endcase
  end

  // datapath and result generation
  always_comb begin
    j_d      = j_q;
    w_d      = w_q;
    fill_d   = fill_q;
    cnt_d    = cnt_q;
    seq_d    = seq_q;
    cmd_d    = cmd_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    out_d    = out_q;
    last_d   = last_q;
    out_v_d  = out_v_q && !out_ready_i;
    wr_en    = 1'b0;
    wr_idx   = j_idx;
    wr_tag   = cur_tag;
    wr_phase = cur_phase;
    wr_sn    = cur_sn;
    wr_wait  = cur_wait;
    age_all  = 1'b0;
    gen      = 1'b0;
    gen_res  = '{kind: ars_pkg::KIND_NONE, tag: '0, sn: '0, attempt: 2'd0};

    unique case (state_q)
      ars_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          j_d   = '0;
        end
      end
      ars_pkg::ST_ENQ: begin
        if (can_push) begin
          gen         = 1'b1;
          gen_res.tag = cmd_q.tag;
          if (full) begin
            gen_res.kind = ars_pkg::KIND_REJECT;
          end else begin
            gen_res.kind = ars_pkg::KIND_QUEUED;
            wr_en        = 1'b1;
            wr_idx       = fill_q[IW-1:0];
            wr_tag       = cmd_q.tag;
            wr_phase     = ars_pkg::PH_READY;
            fill_d       = fill_q + CW'(1);
          end
        end
      end
      ars_pkg::ST_ACK: begin
        if (can_push) begin
          priority if (at_end) begin
            gen          = 1'b1;
            gen_res.kind = ars_pkg::KIND_ACK_MISS;
            gen_res.sn   = cmd_q.sn;
          end else if (ack_hit) begin
            gen          = 1'b1;
            gen_res.kind = ars_pkg::KIND_ACK_HIT;
            gen_res.tag  = cur_tag;
            gen_res.sn   = cmd_q.sn;
            wr_en        = 1'b1;
            wr_phase     = ars_pkg::PH_SUCC;
          end else begin
            j_d = j_q + CW'(1);
          end
        end
      end
      ars_pkg::ST_SEND: begin
        if (can_push && !at_end) begin
          priority if (send_new) begin
            seq_d           = seq_q + 8'd1;
            wr_en           = 1'b1;
            wr_sn           = seq_q + 8'd1;
            wr_wait         = '0;
            wr_phase        = ars_pkg::PH_SENT1;
            gen             = 1'b1;
            gen_res.kind    = ars_pkg::KIND_TRANSMIT;
            gen_res.tag     = cur_tag;
            gen_res.sn      = seq_q + 8'd1;
            gen_res.attempt = 2'd1;
          end else if (send_re) begin
            wr_en    = 1'b1;
            wr_wait  = '0;
            wr_phase = ph_inc;
            if (ph_inc == ars_pkg::PH_FAIL) begin
              j_d = j_q + CW'(1);
            end else begin
              gen             = 1'b1;
              gen_res.kind    = ars_pkg::KIND_TRANSMIT;
              gen_res.tag     = cur_tag;
              gen_res.sn      = cur_sn;
              gen_res.attempt = 2'(3'(ph_inc) - 3'(ars_pkg::PH_READY));
            end
          end else begin
            j_d = j_q + CW'(1);
          end
        end
      end
      ars_pkg::ST_AGE: begin
        if (can_push) begin
          age_all = 1'b1;
          j_d     = '0;
          w_d     = '0;
          cnt_d   = '0;
        end
      end
      ars_pkg::ST_PACK: begin
        if (can_push) begin
          priority if (at_end) begin
            fill_d = w_q;
          end else if (rep_now) begin
            gen          = 1'b1;
            gen_res.kind = (cur_phase == ars_pkg::PH_SUCC) ? ars_pkg::KIND_DONE_OK
                                                            : ars_pkg::KIND_DONE_ERR;
            gen_res.tag  = cur_tag;
            gen_res.sn   = cur_sn;
            cnt_d        = cnt_q + ars_pkg::CNT_W'(1);
            j_d          = j_q + CW'(1);
          end else begin
            // keep entry, move it down over the removed ones
            wr_en  = 1'b1;
            wr_idx = w_q[IW-1:0];
            w_d    = w_q + CW'(1);
            j_d    = j_q + CW'(1);
          end
        end
      end
      ars_pkg::ST_FINAL: begin
        if (can_push) begin
          out_v_d  = 1'b1;
          last_d   = 1'b1;
          out_d    = pend_v_q ? pend_q : gen_res;
          pend_v_d = 1'b0;
        end
      end
      default: ;
    endcase

    if (gen) begin
      if (pend_v_q) begin
        out_d   = pend_q;
        last_d  = 1'b0;
        out_v_d = 1'b1;
      end
      pend_d   = gen_res;
      pend_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ars_pkg::ST_IDLE;
      j_q      <= '0;
      w_q      <= '0;
      fill_q   <= '0;
      cnt_q    <= '0;
      seq_q    <= '0;
      tmo_q    <= ars_pkg::TIMEOUT_RESET;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      j_q      <= j_d;
      w_q      <= w_d;
      fill_q   <= fill_d;
      cnt_q    <= cnt_d;
      seq_q    <= seq_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      if (cfg_valid_i) begin
        tmo_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    pend_q <= pend_d;
    out_q  <= out_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        phase_q[i] <= ars_pkg::PH_EMPTY;
      end
    end else if (wr_en) begin
      phase_q[wr_idx] <= wr_phase;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tag_q[wr_idx] <= wr_tag;
      sn_q[wr_idx]  <= wr_sn;
    end
  end

  always_ff @(posedge clk_i) begin
    if (age_all) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if ((CW'(i) < fill_q) && ars_pkg::in_flight(phase_q[i]) &&
            (wait_q[i] != ars_pkg::WAIT_MAX)) begin
          wait_q[i] <= wait_q[i] + 8'd1;
        end
      end
    end else if (wr_en) begin
      wait_q[wr_idx] <= wr_wait;
    end
  end

endmodule

@@ design/ack_retransmit_send_queue_unit.sv @@
// top level of the acknowledge and retransmit send queue
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------
//  input    | in_valid_i / in_ready_o | cmd_i, msg_tag_i, ack_sn_i
//  result   | out_valid_o/out_ready_i | kind_o, tag_out_o, sn_out_o, attempt_o,
//           |                         | last_o
//  config   | cfg_valid_i/cfg_ready_o | cfg_data_i (timeout_ticks)
//
// an enqueue passes ST_ENQ and ST_FINAL, an unused command only ST_FINAL, an ack a slot scan in ST_ACK
// a service step scans in ST_SEND, ages in ST_AGE and packs in ST_PACK, one slot per cycle unless the result stalls
// a two-entry command queue takes new items while the back end works
// reset empties the queue, clears the sequence counter and sets the timeout to 10; no clearing pass
// a stalled result register holds the back end
module ack_retransmit_send_queue_unit #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] msg_tag_i,
  input  logic [7:0] ack_sn_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] kind_o,
  output logic [7:0] tag_out_o,
  output logic [7:0] sn_out_o,
  output logic [1:0] attempt_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  logic          cmd_valid;
  ars_pkg::cmd_t cmd;
  logic          cmd_pop;
  ars_pkg::res_t res;

  assign cfg_ready_o = 1'b1;

  ars_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .msg_tag_i   (msg_tag_i),
    .ack_sn_i    (ack_sn_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  ars_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res),
    .last_o      (last_o)
  );

  assign kind_o    = res.kind;
  assign tag_out_o = res.tag;
  assign sn_out_o  = res.sn;
  assign attempt_o = res.attempt;

endmodule

@@ design/ars_checker.sv @@
// port-level checker for the send queue, bound to the top level
module ars_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] kind_o,
  input logic [7:0] tag_out_o,
  input logic [7:0] sn_out_o,
  input logic [1:0] attempt_o,
  input logic       last_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(tag_out_o)
      && $stable(sn_out_o) && $stable(attempt_o) && $stable(last_o))
    else $error("result changed while stalled");

  // transmit carries attempt 1..3, all other kinds zero
  a_attempt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((kind_o == ars_pkg::KIND_TRANSMIT) == (attempt_o != 2'd0)))
    else $error("attempt does not match kind");

  // single-result commands always close the item
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == ars_pkg::KIND_QUEUED || kind_o == ars_pkg::KIND_REJECT ||
      kind_o == ars_pkg::KIND_ACK_HIT || kind_o == ars_pkg::KIND_ACK_MISS ||
      kind_o == ars_pkg::KIND_NONE) |-> last_o)
    else $error("single result without last");

  // nothing and ack miss name no handle
  a_no_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == ars_pkg::KIND_NONE || kind_o == ars_pkg::KIND_ACK_MISS)
      |-> tag_out_o == 8'd0)
    else $error("handle on empty result");

endmodule

bind ack_retransmit_send_queue_unit ars_checker u_ars_checker (.*);
